>>> hw/rtl/tksl_pkg.sv
// ----------------------------------------------------------------------------
// Top-k sorted strength list: shared definitions
// Sizes, operation and status codes, state type and the command that the
// list controller broadcasts to every cell.
// ----------------------------------------------------------------------------
package tksl_pkg;

   // List geometry.
   localparam int LIST_DEPTH    = 16;
   localparam int HANDLE_BITS   = 16;
   localparam int STRENGTH_BITS = 32;

   // Derived index and count widths.
   localparam int POS_BITS  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(LIST_DEPTH + 1);

   // Fixed field widths of the ports.
   localparam int CAP_BITS      = 5;
   localparam int REQ_POS_BITS  = 4;
   localparam int FPOS_BITS     = 4;
   localparam int COUNT_OUT_BITS = 5;

   // Widths used to compare or convert values of differing sizes.
   localparam int CAPCMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;
   localparam int PIDX_BITS   = (POS_BITS > REQ_POS_BITS) ? POS_BITS : REQ_POS_BITS;
   localparam int POSCMP_BITS = (CNT_BITS > REQ_POS_BITS) ? CNT_BITS : REQ_POS_BITS;
   localparam int ENC_BITS    = (POS_BITS > FPOS_BITS) ? POS_BITS : FPOS_BITS;
   localparam int CNTOUT_EXT  = (CNT_BITS > COUNT_OUT_BITS) ? CNT_BITS : COUNT_OUT_BITS;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // Operation codes.
   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_INC   = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   // Status codes.
   typedef enum logic [1:0] {
      STAT_DONE   = 2'd0,
      STAT_REJECT = 2'd1,
      STAT_RANGE  = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_APPLY = 1'b1
   } state_type;

   // Command seen by one cell during the apply cycle.
   typedef struct packed {
      logic                      clear;
      logic                      apply;
      logic                      in_range;      // cell index is at or above the target slot
      logic                      below_target;  // cell index is strictly above the target slot
      logic [STRENGTH_BITS-1:0]  strength;
      logic [HANDLE_BITS-1:0]    handle;
   } cell_cmd_type;

endpackage

>>> hw/rtl/tksl_cell.sv
// ----------------------------------------------------------------------------
// Top-k sorted strength list: one list cell
// Holds one (strength, handle) entry. During an apply cycle it keeps its
// entry, takes its upper neighbor's or the new one, or zeroes its strength.
// ----------------------------------------------------------------------------
module tksl_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tksl_pkg::cell_cmd_type                 cmd,
   input  logic                                   upper_gt,
   input  logic [tksl_pkg::STRENGTH_BITS-1:0]     upper_strength,
   input  logic [tksl_pkg::HANDLE_BITS-1:0]       upper_handle,
   output logic [tksl_pkg::STRENGTH_BITS-1:0]     strength,
   output logic [tksl_pkg::HANDLE_BITS-1:0]       handle,
   output logic                                   gt,
   output logic                                   insert
);

   logic [tksl_pkg::STRENGTH_BITS-1:0] strength_ff;
   logic [tksl_pkg::STRENGTH_BITS-1:0] strength_in;
   logic [tksl_pkg::HANDLE_BITS-1:0]   handle_ff;
   logic [tksl_pkg::HANDLE_BITS-1:0]   handle_in;
   logic                               shift;

   // This entry stays above the moving entry when it is strictly stronger.
   assign gt = cmd.below_target && (strength_ff > cmd.strength);

   // The moving entry lands in the first cell whose upper neighbor stays put.
   assign insert = cmd.apply && cmd.in_range && upper_gt && !gt;
   assign shift  = cmd.apply && cmd.in_range && !upper_gt;

   // Next entry contents.
   always_comb begin
      strength_in = strength_ff;
      handle_in   = handle_ff;
      if (cmd.clear) begin
         strength_in = '0;
      end else if (insert) begin
         strength_in = cmd.strength;
         handle_in   = cmd.handle;
      end else if (shift) begin
         strength_in = upper_strength;
         handle_in   = upper_handle;
      end
   end

   // Strength clears at reset; the handle is only read once written.
   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= '0;
      end else begin
         strength_ff <= strength_in;
      end
      handle_ff <= handle_in;
   end

   assign strength = strength_ff;
   assign handle   = handle_ff;

endmodule

>>> hw/rtl/top_k_sorted_strength_list.sv
// ----------------------------------------------------------------------------
// Top-k sorted strength list
// Keeps up to a configured number of (strength, handle) entries sorted by
// descending strength in a row of cells, with add, increment and clear.
//
// Usage:
//   An item (req_func, req_strength, req_handle, req_position) is taken at a
//   rising edge where start is high and busy is low. Busy is high for the one
//   apply cycle that follows. The result item appears on the rsp_ ports for
//   one cycle, marked by rsp_valid, in the cycle after the apply cycle, which
//   is also a cycle in which a new item may be started.
//   A new item is not taken while busy. In the accept cycle the front end reads
//   one selected cell and does the saturating add and the accept/reject
//   checks; in the apply cycle every cell compares and shifts in parallel.
//   The user writes the capacity register through csr_we/csr_wdata only while
//   idle; the block itself does not enforce it. Reset (synchronous) empties
//   the list, zeroes all strengths and sets the capacity to 16. The receiver
//   cannot stall: each result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module top_k_sorted_strength_list (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [1:0]                               req_func,
   input  logic [tksl_pkg::STRENGTH_BITS-1:0]       req_strength,
   input  logic [tksl_pkg::HANDLE_BITS-1:0]         req_handle,
   input  logic [tksl_pkg::REQ_POS_BITS-1:0]        req_position,
   output logic                                     rsp_valid,
   output logic [tksl_pkg::FPOS_BITS-1:0]           rsp_final_position,
   output logic [1:0]                               rsp_status,
   output logic                                     rsp_evicted_valid,
   output logic [tksl_pkg::HANDLE_BITS-1:0]         rsp_evicted_handle,
   output logic [tksl_pkg::COUNT_OUT_BITS-1:0]      rsp_entry_count,
   input  logic                                     csr_we,
   input  logic [tksl_pkg::CAP_BITS-1:0]            csr_wdata
);

   localparam int DEPTH = tksl_pkg::LIST_DEPTH;
   localparam int SW    = tksl_pkg::STRENGTH_BITS;
   localparam int HW    = tksl_pkg::HANDLE_BITS;
   localparam int PW    = tksl_pkg::POS_BITS;
   localparam int CW    = tksl_pkg::CNT_BITS;

   // Control state.
   tksl_pkg::state_type state_ff, state_in;
   logic [tksl_pkg::CAP_BITS-1:0] cap_ff, cap_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic                          accept;
   logic                          apply_cycle;

   // Operation latched at accept.
   logic           op_apply_ff, op_apply_in;
   logic           op_clear_ff, op_clear_in;
   logic [SW-1:0]  op_strength_ff, op_strength_in;
   logic [HW-1:0]  op_handle_ff, op_handle_in;
   logic [PW-1:0]  op_pos_ff, op_pos_in;
   logic [1:0]     op_status_ff, op_status_in;
   logic           op_ev_valid_ff, op_ev_valid_in;
   logic [HW-1:0]  op_ev_handle_ff, op_ev_handle_in;

   // Result registers.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [tksl_pkg::FPOS_BITS-1:0]       rsp_fpos_ff, rsp_fpos_in;
   logic [1:0]                           rsp_status_ff;
   logic                                 rsp_ev_valid_ff;
   logic [HW-1:0]                        rsp_ev_handle_ff;
   logic [tksl_pkg::COUNT_OUT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   // Cell row.
   tksl_pkg::cell_cmd_type cell_cmd [DEPTH];
   logic [SW-1:0]          cell_str [DEPTH];
   logic [HW-1:0]          cell_hnd [DEPTH];
   logic [DEPTH-1:0]       cell_gt;
   logic [DEPTH-1:0]       insert_vec;
   logic                   up_gt  [DEPTH];
   logic [SW-1:0]          up_str [DEPTH];
   logic [HW-1:0]          up_hnd [DEPTH];

   // Front-end decode signals.
   logic [tksl_pkg::CAPCMP_BITS-1:0]  cap_wide, cap_eff, count_cap;
   logic                              grew;
   logic [CW-1:0]                     count_grown, last_wide;
   logic [PW-1:0]                     last_idx, pos_idx, sel_idx;
   logic [tksl_pkg::PIDX_BITS-1:0]    pos_ext;
   logic                              pos_ok;
   logic [SW-1:0]                     sel_str, sat_sum;
   logic [HW-1:0]                     sel_hnd;
   logic [SW:0]                       sum_wide;
   logic [tksl_pkg::ENC_BITS-1:0]     enc_ext;
   logic [PW-1:0]                     enc_pos;
   logic [tksl_pkg::CNTOUT_EXT-1:0]   count_ext;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tksl_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tksl_pkg::ST_APPLY;
            end
         end
         tksl_pkg::ST_APPLY: begin
            state_in = tksl_pkg::ST_IDLE;
         end
         default: begin
            state_in = tksl_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      busy        = 1'b0;
      apply_cycle = 1'b0;
      case (state_ff)
         tksl_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         tksl_pkg::ST_APPLY: begin
            busy        = 1'b1;
            apply_cycle = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign accept = start && !busy;

   // Capacity register.
   assign cap_in = csr_we ? csr_wdata : cap_ff;

   // Slot selection: the given position for an increment, the last slot otherwise.
   always_comb begin
      cap_wide    = tksl_pkg::CAPCMP_BITS'(cap_ff);
      cap_eff     = (cap_wide > tksl_pkg::CAPCMP_BITS'(DEPTH)) ?
                    tksl_pkg::CAPCMP_BITS'(DEPTH) : cap_wide;
      count_cap   = tksl_pkg::CAPCMP_BITS'(count_ff);
      grew        = cap_eff > count_cap;
      count_grown = count_ff + CW'(grew);
      last_wide   = count_grown - CW'(1);
      last_idx    = last_wide[PW-1:0];
      pos_ext     = tksl_pkg::PIDX_BITS'(req_position);
      pos_idx     = pos_ext[PW-1:0];
      pos_ok      = tksl_pkg::POSCMP_BITS'(req_position) < tksl_pkg::POSCMP_BITS'(count_ff);
      sel_idx     = (req_func == tksl_pkg::FUNC_INC) ? pos_idx : last_idx;
      sel_str     = cell_str[sel_idx];
      sel_hnd     = cell_hnd[sel_idx];
      sum_wide    = {1'b0, sel_str} + {1'b0, req_strength};
      sat_sum     = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
   end

   // Operation decode at accept.
   always_comb begin
      op_apply_in     = 1'b0;
      op_clear_in     = 1'b0;
      op_strength_in  = req_strength;
      op_handle_in    = req_handle;
      op_pos_in       = last_idx;
      op_status_in    = tksl_pkg::STAT_DONE;
      op_ev_valid_in  = 1'b0;
      op_ev_handle_in = '0;
      count_in        = count_ff;
      case (req_func)
         tksl_pkg::FUNC_ADD: begin
            count_in = count_grown;
            if (count_grown == '0) begin
               op_status_in = tksl_pkg::STAT_REJECT;
            end else if (req_strength < sel_str) begin
               op_status_in = tksl_pkg::STAT_REJECT;
            end else begin
               op_apply_in = 1'b1;
               if (!grew) begin
                  op_ev_valid_in  = 1'b1;
                  op_ev_handle_in = sel_hnd;
               end
            end
         end
         tksl_pkg::FUNC_INC: begin
            op_pos_in = pos_idx;
            if (!pos_ok) begin
               op_status_in = tksl_pkg::STAT_RANGE;
            end else begin
               op_apply_in    = 1'b1;
               op_strength_in = sat_sum;
               op_handle_in   = sel_hnd;
            end
         end
         tksl_pkg::FUNC_CLEAR: begin
            op_clear_in = 1'b1;
            count_in    = '0;
         end
         default: begin
            op_apply_in = 1'b0;
         end
      endcase
   end

   // Broadcast command to the cells during the apply cycle.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_cmd[i].clear        = apply_cycle && op_clear_ff;
         cell_cmd[i].apply        = apply_cycle && op_apply_ff;
         cell_cmd[i].in_range     = PW'(i) <= op_pos_ff;
         cell_cmd[i].below_target = PW'(i) < op_pos_ff;
         cell_cmd[i].strength     = op_strength_ff;
         cell_cmd[i].handle       = op_handle_ff;
      end
   end

   // Row of cells, each fed by its upper neighbor.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign up_gt[g]  = 1'b1;
         assign up_str[g] = '0;
         assign up_hnd[g] = '0;
      end else begin : g_link
         assign up_gt[g]  = cell_gt[g-1];
         assign up_str[g] = cell_str[g-1];
         assign up_hnd[g] = cell_hnd[g-1];
      end

      tksl_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cell_cmd[g]),
         .upper_gt       (up_gt[g]),
         .upper_strength (up_str[g]),
         .upper_handle   (up_hnd[g]),
         .strength       (cell_str[g]),
         .handle         (cell_hnd[g]),
         .gt             (cell_gt[g]),
         .insert         (insert_vec[g])
      );
   end

   // Landing slot of the moving entry.
   always_comb begin
      enc_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (insert_vec[i]) begin
            enc_pos = enc_pos | PW'(i);
         end
      end
      enc_ext = tksl_pkg::ENC_BITS'(enc_pos);
   end

   // Result values.
   always_comb begin
      rsp_valid_in = apply_cycle;
      rsp_fpos_in  = op_apply_ff ? enc_ext[tksl_pkg::FPOS_BITS-1:0] : '0;
      count_ext    = tksl_pkg::CNTOUT_EXT'(count_ff);
      rsp_count_in = count_ext[tksl_pkg::COUNT_OUT_BITS-1:0];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tksl_pkg::ST_IDLE;
         cap_ff       <= tksl_pkg::CAP_RESET;
         count_ff     <= '0;
         op_apply_ff  <= 1'b0;
         op_clear_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff    <= count_in;
            op_apply_ff <= op_apply_in;
            op_clear_ff <= op_clear_in;
         end
      end
   end

   // Operation and result payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_strength_ff  <= op_strength_in;
         op_handle_ff    <= op_handle_in;
         op_pos_ff       <= op_pos_in;
         op_status_ff    <= op_status_in;
         op_ev_valid_ff  <= op_ev_valid_in;
         op_ev_handle_ff <= op_ev_handle_in;
      end
      if (apply_cycle) begin
         rsp_fpos_ff      <= rsp_fpos_in;
         rsp_status_ff    <= op_status_ff;
         rsp_ev_valid_ff  <= op_ev_valid_ff;
         rsp_ev_handle_ff <= op_ev_handle_ff;
         rsp_count_ff     <= rsp_count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_final_position = rsp_fpos_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_evicted_valid  = rsp_ev_valid_ff;
   assign rsp_evicted_handle = rsp_ev_handle_ff;
   assign rsp_entry_count    = rsp_count_ff;

   // At most one cell ever takes the moving entry.
   a_insert_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0(insert_vec))
      else $error("more than one cell took the moving entry");

   // An applied operation always places its entry in exactly one cell.
   a_insert_once: assert property (@(posedge clock) disable iff (reset)
      (apply_cycle && op_apply_ff) |-> $onehot(insert_vec))
      else $error("applied entry was not placed in exactly one cell");

   // The entry count never exceeds the list depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds list depth");

   // A result strobe follows an apply cycle and nothing else.
   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(apply_cycle))
      else $error("result strobe without a preceding apply cycle");

   // The apply cycle lasts exactly one cycle.
   a_busy_single: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held for more than one cycle");

endmodule
